// ===== hdl/text_console_scrollback_assert.svh =====
// ----------------------------------------------------------------------------
// Scrollback assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLLBACK_ASSERT_SVH
`define TEXT_CONSOLE_SCROLLBACK_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Scrollback package
// Field types, character and request codes, controller/datapath links.
// ----------------------------------------------------------------------------
package tcs_pkg;

  typedef logic [1:0]         mode_t;
  typedef logic [7:0]         char_t;
  typedef logic [4:0]         cnt_t;
  typedef logic [4:0]         cfg_t;
  typedef logic signed [31:0] time_t;

  localparam mode_t MODE_PUT     = 2'd0;
  localparam mode_t MODE_READ    = 2'd1;
  localparam mode_t MODE_COUNT   = 2'd2;
  localparam mode_t MODE_DISCARD = 2'd3;

  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_SPACE = 8'h20;

  localparam time_t ANCIENT_TIME = -32'sd10000;
  localparam cfg_t  CFG_RESET    = 5'd4;

  typedef struct packed {
    logic load;
    logic discard;
    logic scroll;
    logic put_char;
    logic rd_issue;
    logic rd_finish;
    logic cnt_issue;
    logic cnt_step;
    logic cnt_finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic is_lf;
    logic is_cr;
    logic cnt_end;
    logic time_less;
    logic slot_free;
  } dp_stat_t;

endpackage

// ===== hdl/tcs_ram.sv =====
// ----------------------------------------------------------------------------
// Scrollback RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Scrollback controller
// Request sequencer: accepts requests, steps the datapath, posts the result.
// ----------------------------------------------------------------------------
module tcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tcs_pkg::mode_t     in_mode,
  output logic               in_stall,
  output tcs_pkg::ctrl_cmd_t cmd,
  input  tcs_pkg::dp_stat_t  stat
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PUT  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_RDD  = 7'b0001000,
    S_CRD  = 7'b0010000,
    S_CCMP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   can_take;
  logic   take;

  assign can_take = (state_r == S_IDLE) || ((state_r == S_DONE) && stat.slot_free);
  assign in_stall = !can_take;
  assign take     = can_take && in_valid;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_PUT: begin
        if (stat.full) begin
          cmd.scroll = 1'b1;
        end else if (stat.is_lf) begin
          cmd.scroll = 1'b1;
          state_nxt  = S_DONE;
        end else if (stat.is_cr) begin
          state_nxt = S_DONE;
        end else begin
          cmd.put_char = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDD;
      end
      S_RDD: begin
        cmd.rd_finish = 1'b1;
        state_nxt     = S_DONE;
      end
      S_CRD: begin
        if (stat.cnt_end) begin
          cmd.cnt_finish = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.cnt_issue = 1'b1;
          state_nxt     = S_CCMP;
        end
      end
      S_CCMP: begin
        if (stat.time_less) begin
          cmd.cnt_finish = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.cnt_step = 1'b1;
          state_nxt    = S_CRD;
        end
      end
      S_DONE: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (take) begin
      cmd.load = 1'b1;
      case (in_mode)
        tcs_pkg::MODE_PUT:   state_nxt = S_PUT;
        tcs_pkg::MODE_READ:  state_nxt = S_RD;
        tcs_pkg::MODE_COUNT: state_nxt = S_CRD;
        default: begin
          cmd.discard = 1'b1;
          state_nxt   = S_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/tcs_dp.sv =====
// ----------------------------------------------------------------------------
// Scrollback datapath
// Ring pointers, line stores, read and count logic, result register.
// ----------------------------------------------------------------------------
module tcs_dp #(
  parameter int LINES          = 32,
  parameter int COLS           = 80,
  parameter int MAX_LAST_LINES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcs_pkg::char_t     in_char_in,
  input  logic [4:0]         in_line_back,
  input  logic [6:0]         in_column,
  input  tcs_pkg::time_t     in_now_time,
  input  tcs_pkg::time_t     in_query_time,
  input  logic               cfg_valid,
  input  tcs_pkg::cfg_t      cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcs_pkg::char_t     out_char_out,
  output logic               out_line_present,
  output tcs_pkg::cnt_t      out_newer_count,
  input  tcs_pkg::ctrl_cmd_t cmd,
  output tcs_pkg::dp_stat_t  stat
);

  localparam int RW  = $clog2(LINES);
  localparam int NW  = $clog2(LINES + 1);
  localparam int CLW = $clog2(COLS + 1);
  localparam int CA  = $clog2(LINES * COLS);
  localparam int CW  = $clog2(MAX_LAST_LINES + 1);
  localparam int DW  = ((RW > 5) ? RW : 5) + 1;

  // request fields
  tcs_pkg::char_t char_r;
  logic [4:0]     back_r;
  logic [6:0]     col_r;
  tcs_pkg::time_t now_r;
  tcs_pkg::time_t query_r;

  // ring state
  logic [RW-1:0]  top_r, top_nxt;
  logic [CLW-1:0] cursor_r, cursor_nxt;
  logic [NW-1:0]  lp_r, lp_nxt;
  logic [NW-1:0]  fresh_r, fresh_nxt;
  logic           disc_r, disc_nxt;
  tcs_pkg::cfg_t  cfg_r, cfg_nxt;

  // count walk
  logic [CW-1:0]  i_r, i_nxt;
  logic [RW-1:0]  krow_r, krow_nxt;
  logic [RW-1:0]  kmod_r, kmod_nxt;

  // result and output
  tcs_pkg::char_t res_char_r, res_char_nxt;
  logic           res_pres_r, res_pres_nxt;
  tcs_pkg::cnt_t  res_cnt_r, res_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  tcs_pkg::char_t out_char_r;
  logic           out_pres_r;
  tcs_pkg::cnt_t  out_cnt_r;

  logic [RW-1:0]  top_inc;
  logic [DW-1:0]  diff;
  logic [RW-1:0]  row_rd;
  logic           pres;
  logic           col_ok;
  logic           rd_en;
  logic [CA-1:0]  char_waddr, char_raddr;
  tcs_pkg::char_t char_rdata;
  logic [CLW-1:0] len_rdata, len_cur;
  logic [31:0]    time_rdata;
  tcs_pkg::time_t time_val;
  logic [CW-1:0]  limit;
  logic           slot_free;

  assign top_inc = (top_r == RW'(LINES - 1)) ? '0 : top_r + 1'b1;
  assign diff    = DW'(top_r) - DW'(back_r);
  assign row_rd  = diff[DW-1] ? RW'(diff + DW'(LINES)) : RW'(diff);
  assign pres    = 32'(back_r) < 32'(lp_r);
  assign col_ok  = 32'(col_r) < 32'(COLS);
  assign rd_en   = cmd.rd_issue && pres && col_ok;

  assign char_waddr = CA'(top_r) * CA'(COLS) + CA'(cursor_r);
  assign char_raddr = CA'(row_rd) * CA'(COLS) + CA'(col_r);

  assign len_cur  = (back_r == '0) ? cursor_r : len_rdata;
  assign time_val = (32'(kmod_r) < 32'(fresh_r)) ? $signed(time_rdata) :
                    (disc_r ? tcs_pkg::ANCIENT_TIME : '0);
  assign limit    = (32'(cfg_r) > 32'(MAX_LAST_LINES)) ? CW'(MAX_LAST_LINES) : CW'(cfg_r);
  assign slot_free = !out_valid_r || !out_stall;

  tcs_ram #(.WIDTH(8), .DEPTH(LINES * COLS)) u_char_ram (
    .clk   (clk),
    .we    (cmd.put_char),
    .waddr (char_waddr),
    .wdata (char_r),
    .re    (rd_en),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  tcs_ram #(.WIDTH(CLW), .DEPTH(LINES)) u_len_ram (
    .clk   (clk),
    .we    (cmd.scroll),
    .waddr (top_r),
    .wdata (cursor_r),
    .re    (rd_en),
    .raddr (row_rd),
    .rdata (len_rdata)
  );

  tcs_ram #(.WIDTH(32), .DEPTH(LINES)) u_time_ram (
    .clk   (clk),
    .we    (cmd.scroll),
    .waddr (top_inc),
    .wdata (now_r),
    .re    (cmd.cnt_issue),
    .raddr (krow_r),
    .rdata (time_rdata)
  );

  always_comb begin
    top_nxt       = top_r;
    cursor_nxt    = cursor_r;
    lp_nxt        = lp_r;
    fresh_nxt     = fresh_r;
    disc_nxt      = disc_r;
    cfg_nxt       = cfg_r;
    i_nxt         = i_r;
    krow_nxt      = krow_r;
    kmod_nxt      = kmod_r;
    res_char_nxt  = res_char_r;
    res_pres_nxt  = res_pres_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;

    if (cfg_valid) begin
      cfg_nxt = cfg_data;
    end
    if (cmd.load) begin
      i_nxt        = '0;
      krow_nxt     = top_r;
      kmod_nxt     = '0;
      res_char_nxt = '0;
      res_pres_nxt = 1'b0;
      res_cnt_nxt  = '0;
    end
    if (cmd.discard) begin
      disc_nxt  = 1'b1;
      fresh_nxt = '0;
    end
    if (cmd.scroll) begin
      top_nxt    = top_inc;
      cursor_nxt = '0;
      if (32'(lp_r) < 32'(LINES)) begin
        lp_nxt = lp_r + 1'b1;
      end
      if (32'(fresh_r) < 32'(LINES)) begin
        fresh_nxt = fresh_r + 1'b1;
      end
    end
    if (cmd.put_char) begin
      cursor_nxt = cursor_r + 1'b1;
    end
    if (cmd.rd_finish) begin
      res_pres_nxt = pres;
      if (pres && col_ok) begin
        res_char_nxt = (32'(col_r) < 32'(len_cur)) ? char_rdata : tcs_pkg::CH_SPACE;
      end
    end
    if (cmd.cnt_step) begin
      i_nxt    = i_r + 1'b1;
      krow_nxt = (krow_r == '0) ? RW'(LINES - 1) : krow_r - 1'b1;
      kmod_nxt = (kmod_r == RW'(LINES - 1)) ? '0 : kmod_r + 1'b1;
    end
    if (cmd.cnt_finish) begin
      res_cnt_nxt = tcs_pkg::cnt_t'(i_r);
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      cursor_r    <= '0;
      lp_r        <= '0;
      fresh_r     <= '0;
      disc_r      <= 1'b0;
      cfg_r       <= tcs_pkg::CFG_RESET;
      i_r         <= '0;
      krow_r      <= '0;
      kmod_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      cursor_r    <= cursor_nxt;
      lp_r        <= lp_nxt;
      fresh_r     <= fresh_nxt;
      disc_r      <= disc_nxt;
      cfg_r       <= cfg_nxt;
      i_r         <= i_nxt;
      krow_r      <= krow_nxt;
      kmod_r      <= kmod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r  <= in_char_in;
      back_r  <= in_line_back;
      col_r   <= in_column;
      now_r   <= in_now_time;
      query_r <= in_query_time;
    end
    res_char_r <= res_char_nxt;
    res_pres_r <= res_pres_nxt;
    res_cnt_r  <= res_cnt_nxt;
    if (cmd.out_load) begin
      out_char_r <= res_char_r;
      out_pres_r <= res_pres_r;
      out_cnt_r  <= res_cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_out     = out_char_r;
  assign out_line_present = out_pres_r;
  assign out_newer_count  = out_cnt_r;

  assign stat.full      = (32'(cursor_r) >= 32'(COLS));
  assign stat.is_lf     = (char_r == tcs_pkg::CH_LF);
  assign stat.is_cr     = (char_r == tcs_pkg::CH_CR);
  assign stat.cnt_end   = (i_r == limit);
  assign stat.time_less = (time_val < query_r);
  assign stat.slot_free = slot_free;

endmodule

// ===== hdl/text_console_scrollback.sv =====
// ----------------------------------------------------------------------------
// Text console scrollback
// Ring of LINES x COLS character cells with per-line tick stamps.
// ----------------------------------------------------------------------------
// Requests enter on in_* (valid/stall) and each gives one result on out_*.
// Modes: 0 appends a character, 1 reads a cell of a past line, 2 counts the
// recent lines stamped no earlier than in_query_time, 3 marks all stamps old.
// cfg_* writes last_lines_shown; cfg_ready is always high.
// Each request follows the controller sequence and the registered RAM
// reads: mode 0 scrolls first when the line is full, mode 1 issues a read
// and then finishes it, mode 3 goes straight to its result, and mode 2
// examines lines up to the limit, stopping at the first line examined that
// is older than the query; each line costs one time-RAM read and one compare.
// A new request is taken in the cycle its predecessor's result is loaded
// into the output register.
// Reset is synchronous on rst_n and needs no clearing pass: each line keeps
// a written length and cells past it read as spaces; stamps are tracked by
// a fresh-line count, so the block is ready in the cycle after reset.
// While out_stall holds, the result stays in the output register; a following
// request may still be accepted and runs until its own result is due.
// ----------------------------------------------------------------------------
`include "text_console_scrollback_assert.svh"

module text_console_scrollback #(
  parameter int LINES          = 32,
  parameter int COLS           = 80,
  parameter int MAX_LAST_LINES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_char_in,
  input  logic [4:0]            in_line_back,
  input  logic [6:0]            in_column,
  input  logic signed [31:0]    in_now_time,
  input  logic signed [31:0]    in_query_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char_out,
  output logic                  out_line_present,
  output logic [4:0]            out_newer_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [4:0]            cfg_data
);

  tcs_pkg::ctrl_cmd_t cmd;
  tcs_pkg::dp_stat_t  stat;
  logic               in_take;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  tcs_dp #(
    .LINES          (LINES),
    .COLS           (COLS),
    .MAX_LAST_LINES (MAX_LAST_LINES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_char_in       (in_char_in),
    .in_line_back     (in_line_back),
    .in_column        (in_column),
    .in_now_time      (in_now_time),
    .in_query_time    (in_query_time),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_out     (out_char_out),
    .out_line_present (out_line_present),
    .out_newer_count  (out_newer_count),
    .cmd              (cmd),
    .stat             (stat)
  );

  `TCS_ASSERT_IMPL(a_load_free, cmd.out_load, stat.slot_free, "result overwritten")
  `TCS_ASSERT_IMPL(a_put_room, cmd.put_char, !stat.full, "write past line end")
  `TCS_ASSERT_IMPL(a_take_load, in_take, cmd.load, "request not latched")
  `TCS_ASSERT_NEXT(a_read_issue, in_take && (in_mode == tcs_pkg::MODE_READ), cmd.rd_issue, "read")

endmodule
